### design/gvc_pkg.sv
`default_nettype none

package gvc_pkg;

  // Largest graph handled
  localparam int MAX_VERTICES = 7;

  // Vertex index / count field width
  localparam int VTX_W = 3;

  // Packed upper-triangle widths for input and contracted graph
  localparam int IN_W  = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
  localparam int OUT_W = (MAX_VERTICES - 1) * (MAX_VERTICES - 2) / 2;

  // Symmetric adjacency matrix, one row per vertex
  typedef logic [MAX_VERTICES-1:0] adj_row_t;
  typedef adj_row_t [MAX_VERTICES-1:0] adj_t;

  // Request fields that ride along the pipeline
  typedef struct packed {
    logic [VTX_W-1:0] vertex_count;
    logic [VTX_W-1:0] keep_vertex;
    logic [VTX_W-1:0] drop_vertex;
    logic             invalid;
  } req_t;

  // Bit position of edge (i,j), i < j, in the packed mask
  function automatic int tri_pos(input int j, input int i);
    return j * (j - 1) / 2 + i;
  endfunction

endpackage

`default_nettype wire

### design/gvc_unpack.sv
`default_nettype none

// Range check and unpack of the edge mask into a symmetric matrix
module gvc_unpack (
  input  wire logic [gvc_pkg::VTX_W-1:0] vertex_count,
  input  wire logic [gvc_pkg::IN_W-1:0]  edge_mask,
  input  wire logic [gvc_pkg::VTX_W-1:0] keep_vertex,
  input  wire logic [gvc_pkg::VTX_W-1:0] drop_vertex,
  output gvc_pkg::adj_t                  adj,
  output gvc_pkg::req_t                  req
);

  // Request check: distinct vertices, both below n, n within range
  always_comb begin
    req.vertex_count = vertex_count;
    req.keep_vertex  = keep_vertex;
    req.drop_vertex  = drop_vertex;
    req.invalid      = ({1'b0, vertex_count} > (gvc_pkg::VTX_W + 1)'(gvc_pkg::MAX_VERTICES)) ||
                       (keep_vertex >= vertex_count) ||
                       (drop_vertex >= vertex_count) ||
                       (keep_vertex == drop_vertex);
  end

  // Edge (i,j) exists only when j lies below n
  always_comb begin
    logic e;
    adj = '0;
    e   = 1'b0;
    for (int j = 1; j < gvc_pkg::MAX_VERTICES; j++) begin
      for (int i = 0; i < j; i++) begin
        e = edge_mask[gvc_pkg::tri_pos(j, i)] &&
            (gvc_pkg::VTX_W'(j) < vertex_count);
        adj[i][j] = e;
        adj[j][i] = e;
      end
    end
  end

endmodule

`default_nettype wire

### design/graph_vertex_contract_mask.sv
`default_nettype none

// Channel | signals                                         | direction
// --------+-------------------------------------------------+----------
// in      | in_valid, in_stall, vertex_count, edge_mask,    | into block
//         | keep_vertex, drop_vertex                        |
// out     | out_valid, out_stall, contracted_mask,          | out of block
//         | invalid_request                                 |
//
// One transaction per cycle sustained while out_stall is low; each passes stage 1, stage 2 and output registers.
// Stages: unpack and check, merge of the vertex pair, renumber and repack.
// Each stage holds its item while the stage after it is full and stalled;
// bubbles collapse, so in_stall rises only with all three stages full.
// rst (synchronous) clears the stage valid bits only.
module graph_vertex_contract_mask (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [gvc_pkg::VTX_W-1:0]  vertex_count,
  input  wire logic [gvc_pkg::IN_W-1:0]   edge_mask,
  input  wire logic [gvc_pkg::VTX_W-1:0]  keep_vertex,
  input  wire logic [gvc_pkg::VTX_W-1:0]  drop_vertex,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [gvc_pkg::OUT_W-1:0]       contracted_mask,
  output logic                            invalid_request
);

  localparam int NV = gvc_pkg::MAX_VERTICES;

  gvc_pkg::adj_t adj_in;
  gvc_pkg::req_t req_in;

  logic          v1, v2, v3;
  logic          rdy1, rdy2, rdy3;
  gvc_pkg::adj_t adj1, merged2, merged_next;
  gvc_pkg::req_t req1, req2;
  logic [gvc_pkg::OUT_W-1:0] mask_next;

  gvc_unpack u_unpack (
    .vertex_count (vertex_count),
    .edge_mask    (edge_mask),
    .keep_vertex  (keep_vertex),
    .drop_vertex  (drop_vertex),
    .adj          (adj_in),
    .req          (req_in)
  );

  // Stage advance: a stage loads when empty or when its successor moves
  assign rdy3     = !v3 || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: unpacked matrix
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      adj1 <= adj_in;
      req1 <= req_in;
    end
  end

  // Merge drop into keep; rows are symmetric so column bits come from rows
  always_comb begin
    gvc_pkg::adj_row_t keep_row, drop_row;
    keep_row    = adj1[req1.keep_vertex];
    drop_row    = adj1[req1.drop_vertex];
    merged_next = adj1;
    for (int a = 0; a < NV; a++) begin
      for (int b = 0; b < NV; b++) begin
        if (gvc_pkg::VTX_W'(a) == req1.keep_vertex) begin
          merged_next[a][b] = (keep_row[b] || drop_row[b]) &&
                              (gvc_pkg::VTX_W'(b) != req1.keep_vertex) &&
                              (gvc_pkg::VTX_W'(b) != req1.drop_vertex);
        end else if (gvc_pkg::VTX_W'(b) == req1.drop_vertex) begin
          merged_next[a][b] = 1'b0;
        end else if (gvc_pkg::VTX_W'(b) == req1.keep_vertex) begin
          merged_next[a][b] = keep_row[a] || drop_row[a];
        end
      end
    end
  end

  // Stage 2: merged matrix
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      merged2 <= merged_next;
      req2    <= req1;
    end
  end

  // Drop the removed row and column, then repack for n-1 vertices
  always_comb begin
    gvc_pkg::adj_t dense;
    dense     = '0;
    mask_next = '0;
    for (int r = 0; r < NV - 1; r++) begin
      gvc_pkg::adj_row_t src;
      src = (gvc_pkg::VTX_W'(r) < req2.drop_vertex) ? merged2[r] : merged2[r+1];
      for (int c = 0; c < NV - 1; c++) begin
        dense[r][c] = (gvc_pkg::VTX_W'(c) < req2.drop_vertex) ? src[c] : src[c+1];
      end
    end
    for (int j = 1; j < NV - 1; j++) begin
      for (int i = 0; i < j; i++) begin
        mask_next[gvc_pkg::tri_pos(j, i)] = dense[i][j] &&
          ((gvc_pkg::VTX_W + 1)'(j + 1) < {1'b0, req2.vertex_count}) &&
          !req2.invalid;
      end
    end
  end

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      contracted_mask <= mask_next;
      invalid_request <= req2.invalid;
    end
  end

endmodule

`default_nettype wire

### design/gvc_checker.sv
`default_nettype none

// Port-level checks on the contraction pipeline
module gvc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [gvc_pkg::OUT_W-1:0]  contracted_mask,
  input wire logic                       invalid_request
);

  // Rejected request always carries an empty mask
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid_request |-> contracted_mask == '0)
    else $error("invalid request with nonzero mask");

  // Input backpressure only when the pipeline is full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output not blocked");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // Stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(contracted_mask) &&
                               $stable(invalid_request))
    else $error("stalled output transaction changed");

endmodule

bind graph_vertex_contract_mask gvc_checker u_gvc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .contracted_mask (contracted_mask),
  .invalid_request (invalid_request)
);

`default_nettype wire

### bench/tb_graph_vertex_contract_mask.sv
module tb_graph_vertex_contract_mask;

  localparam int N_DIRECTED  = 22;
  localparam int N_RANDOM    = 850;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;

  // One contraction outcome as the block reports it
  typedef struct packed {
    logic [gvc_pkg::OUT_W-1:0] mask;
    logic                      invalid;
  } outcome_t;

  // Directed stimulus row; typed rows carry a hand-read expectation
  typedef struct packed {
    logic [gvc_pkg::VTX_W-1:0] n;
    logic [gvc_pkg::IN_W-1:0]  edges;
    logic [gvc_pkg::VTX_W-1:0] keep;
    logic [gvc_pkg::VTX_W-1:0] drop;
    logic                      typed;
    logic [gvc_pkg::OUT_W-1:0] t_mask;
    logic                      t_inv;
  } graph_row_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [gvc_pkg::VTX_W-1:0] vertex_count;
  logic [gvc_pkg::IN_W-1:0]  edge_mask;
  logic [gvc_pkg::VTX_W-1:0] keep_vertex;
  logic [gvc_pkg::VTX_W-1:0] drop_vertex;
  logic                      out_valid;
  logic                      out_stall;
  logic [gvc_pkg::OUT_W-1:0] contracted_mask;
  logic                      invalid_request;

  outcome_t pending_contractions[$];
  int       error_count = 0;
  int       idle_cycles = 0;

  graph_row_t directed_rows [N_DIRECTED] = '{
    // single edge collapses into the removed self-loop
    '{3'd2, 21'h000001, 3'd0, 3'd1, 1'b1, 15'h0000, 1'b0},
    // too few vertices
    '{3'd0, 21'h000000, 3'd0, 3'd0, 1'b1, 15'h0000, 1'b1},
    '{3'd1, 21'h1FFFFF, 3'd0, 3'd0, 1'b1, 15'h0000, 1'b1},
    '{3'd1, 21'h000000, 3'd0, 3'd1, 1'b1, 15'h0000, 1'b1},
    // complete graph K7 contracts to K6
    '{3'd7, 21'h1FFFFF, 3'd0, 3'd6, 1'b1, 15'h7FFF, 1'b0},
    '{3'd7, 21'h1FFFFF, 3'd6, 3'd0, 1'b0, 15'h0000, 1'b0},
    // empty graph stays empty
    '{3'd7, 21'h000000, 3'd3, 3'd5, 1'b1, 15'h0000, 1'b0},
    // equal vertices
    '{3'd7, 21'h1FFFFF, 3'd4, 3'd4, 1'b1, 15'h0000, 1'b1},
    // vertex out of range
    '{3'd7, 21'h1FFFFF, 3'd7, 3'd2, 1'b1, 15'h0000, 1'b1},
    '{3'd7, 21'h1FFFFF, 3'd2, 3'd7, 1'b1, 15'h0000, 1'b1},
    '{3'd5, 21'h1FFFFF, 3'd5, 3'd1, 1'b1, 15'h0000, 1'b1},
    // path 1-2 becomes edge 0-1
    '{3'd3, 21'h000004, 3'd0, 3'd1, 1'b1, 15'h0001, 1'b0},
    // bits only above the used triangle, then assorted patterns
    '{3'd4, 21'h1FFFC0, 3'd1, 3'd3, 1'b0, 15'h0000, 1'b0},
    '{3'd4, 21'h1FFFFF, 3'd3, 3'd1, 1'b0, 15'h0000, 1'b0},
    '{3'd5, 21'h155555, 3'd0, 3'd4, 1'b0, 15'h0000, 1'b0},
    '{3'd5, 21'h0AAAAA, 3'd4, 3'd0, 1'b0, 15'h0000, 1'b0},
    '{3'd6, 21'h0F0F0F, 3'd2, 3'd5, 1'b0, 15'h0000, 1'b0},
    '{3'd6, 21'h1F0F0F, 3'd5, 3'd2, 1'b0, 15'h0000, 1'b0},
    '{3'd7, 21'h155555, 3'd1, 3'd6, 1'b0, 15'h0000, 1'b0},
    '{3'd7, 21'h0AAAAA, 3'd6, 3'd3, 1'b0, 15'h0000, 1'b0},
    '{3'd7, 21'h123456, 3'd5, 3'd4, 1'b0, 15'h0000, 1'b0},
    '{3'd3, 21'h1FFFFF, 3'd2, 3'd0, 1'b0, 15'h0000, 1'b0}
  };

  graph_vertex_contract_mask dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .vertex_count    (vertex_count),
    .edge_mask       (edge_mask),
    .keep_vertex     (keep_vertex),
    .drop_vertex     (drop_vertex),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .contracted_mask (contracted_mask),
    .invalid_request (invalid_request)
  );

  // Merge drop into keep, renumber densely, repack for n-1 vertices
  function automatic outcome_t contract_graph(input logic [gvc_pkg::VTX_W-1:0] n_in,
                                              input logic [gvc_pkg::IN_W-1:0] edges,
                                              input logic [gvc_pkg::VTX_W-1:0] keep,
                                              input logic [gvc_pkg::VTX_W-1:0] drop);
    logic [7:0] adj [8];
    logic [7:0] dense [8];
    int         newidx [8];
    logic [7:0] row;
    int         nv;
    int         pos;
    int         nxt;
    outcome_t   res;
    res = '0;
    nv = n_in;
    if (nv > gvc_pkg::MAX_VERTICES || keep >= nv || drop >= nv || keep == drop) begin
      res.invalid = 1'b1;
      return res;
    end
    for (int a = 0; a < 8; a++) begin
      adj[a] = '0;
      dense[a] = '0;
    end
    // unpack upper triangle; higher bits are never looked at
    pos = 0;
    for (int b = 1; b < nv; b++) begin
      for (int a = 0; a < b; a++) begin
        if (edges[pos]) begin
          adj[a][b] = 1'b1;
          adj[b][a] = 1'b1;
        end
        pos++;
      end
    end
    // merge, drop the self-loop
    adj[keep] = adj[keep] | adj[drop];
    adj[keep][keep] = 1'b0;
    adj[keep][drop] = 1'b0;
    for (int k = 0; k < nv; k++) begin
      if (k != keep && k != drop && adj[k][drop]) begin
        adj[k][drop] = 1'b0;
        adj[k][keep] = 1'b1;
        adj[keep][k] = 1'b1;
      end
    end
    // dense renumbering
    nxt = 0;
    for (int a = 0; a < nv; a++) begin
      newidx[a] = nxt;
      if (a != drop) nxt++;
    end
    for (int a = 0; a < nv; a++) begin
      if (a != drop) begin
        row = '0;
        for (int b = 0; b < nv; b++) begin
          if (b != drop && adj[a][b]) row[newidx[b]] = 1'b1;
        end
        dense[newidx[a]] = row;
      end
    end
    // repack for n-1 vertices
    pos = 0;
    for (int b = 1; b < nv - 1; b++) begin
      for (int a = 0; a < b; a++) begin
        if (pos < gvc_pkg::OUT_W && dense[a][b]) res.mask[pos] = 1'b1;
        pos++;
      end
    end
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $time);
    error_count++;
  endtask

  // Drive one transaction, record its expectation once accepted, then idle if gap is nonzero
  task automatic send_graph(input logic [gvc_pkg::VTX_W-1:0] n,
                            input logic [gvc_pkg::IN_W-1:0] edges,
                            input logic [gvc_pkg::VTX_W-1:0] keep,
                            input logic [gvc_pkg::VTX_W-1:0] drop,
                            input logic typed, input outcome_t typed_out, input int gap);
    @(negedge clk);
    in_valid     <= 1'b1;
    vertex_count <= n;
    edge_mask    <= edges;
    keep_vertex  <= keep;
    drop_vertex  <= drop;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
    if (typed) pending_contractions.push_back(typed_out);
    else pending_contractions.push_back(contract_graph(n, edges, keep, drop));
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stall pattern: short runs, occasional long quiet stretches
  initial begin
    int run;
    int hold;
    out_stall = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      repeat (run) @(negedge clk) out_stall <= 1'b0;
      hold = idle_len();
      repeat (hold) @(negedge clk) out_stall <= 1'b1;
    end
  end

  // Result check against the oldest pending contraction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_contractions.size() == 0) begin
        report_mismatch("unexpected transaction, mask", 0, contracted_mask);
      end else begin
        want = pending_contractions.pop_front();
        if (contracted_mask !== want.mask)
          report_mismatch("contracted_mask", want.mask, contracted_mask);
        if (invalid_request !== want.invalid)
          report_mismatch("invalid_request", want.invalid, invalid_request);
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst === 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_graph_vertex_contract_mask: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    graph_row_t                rw;
    outcome_t                  typed_out;
    logic [gvc_pkg::VTX_W-1:0] n;
    logic [gvc_pkg::VTX_W-1:0] keep;
    logic [gvc_pkg::VTX_W-1:0] drop;
    logic [gvc_pkg::IN_W-1:0]  edges;
    int                        gap;
    rst          = 1'b1;
    in_valid     = 1'b0;
    vertex_count = '0;
    edge_mask    = '0;
    keep_vertex  = '0;
    drop_vertex  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      rw = directed_rows[i];
      typed_out.mask    = rw.t_mask;
      typed_out.invalid = rw.t_inv;
      send_graph(rw.n, rw.edges, rw.keep, rw.drop, rw.typed, typed_out, idle_len());
    end

    // sender holds off until the pipeline has fully drained
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_contractions.size() != 0) @(posedge clk);

    // random graphs: mostly well-formed requests, some raw noise
    typed_out = '0;
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 3))
        0:       edges = gvc_pkg::IN_W'($urandom & $urandom);
        1:       edges = gvc_pkg::IN_W'($urandom | $urandom);
        default: edges = gvc_pkg::IN_W'($urandom);
      endcase
      if ($urandom_range(0, 99) < 80) begin
        n    = gvc_pkg::VTX_W'($urandom_range(2, gvc_pkg::MAX_VERTICES));
        keep = gvc_pkg::VTX_W'($urandom_range(0, n - 1));
        drop = gvc_pkg::VTX_W'($urandom_range(0, n - 2));
        if (drop >= keep) drop = gvc_pkg::VTX_W'(drop + 1);
      end else begin
        n    = gvc_pkg::VTX_W'($urandom);
        keep = gvc_pkg::VTX_W'($urandom);
        drop = gvc_pkg::VTX_W'($urandom);
      end
      // back-to-back stretches at full rate
      gap = ((i / 50) % 5 == 2) ? 0 : idle_len();
      send_graph(n, edges, keep, drop, 1'b0, typed_out, gap);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_contractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_graph_vertex_contract_mask: clean");
    end else begin
      $display("tb_graph_vertex_contract_mask: errors");
    end
    $finish;
  end

endmodule
